// ----- rtl/core/ir_manchester_frame_decoder_core_macros.svh -----
// ----------------------------------------------------------------------------
// IR Manchester frame decoder: assertion macros
// Concurrent checks for simulation; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef IR_MANCHESTER_FRAME_DECODER_CORE_MACROS_SVH
`define IR_MANCHESTER_FRAME_DECODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define IRMFD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define IRMFD_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);
`else
`define IRMFD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define IRMFD_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ----- rtl/core/irmfd_pkg.sv -----
// ----------------------------------------------------------------------------
// IR Manchester frame decoder package
// Field widths, register indices, reset values and shared control types.
// ----------------------------------------------------------------------------
package irmfd_pkg;

  localparam int DUR_W     = 16;
  localparam int UNIT_W    = 16;
  localparam int MARGIN_W  = 16;
  localparam int TICK_W    = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // ticks*tick_us + margin_us fits in one bit over the product
  localparam int DIVD_W    = DUR_W + TICK_W + 1;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_US   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_US = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_US   = 2'd2;

  localparam logic [UNIT_W-1:0]   UNIT_US_RST   = 16'd992;
  localparam logic [MARGIN_W-1:0] MARGIN_US_RST = 16'd150;
  localparam logic [TICK_W-1:0]   TICK_US_RST   = 8'd50;

  localparam int ENTRY_W = 4;
  localparam logic [ENTRY_W-1:0] MIN_ENTRIES = 4'd12;

  localparam logic [5:0] HDR_PATTERN = 6'b000111;

  typedef enum logic [1:0] {
    V_PENDING = 2'd0,
    V_OK      = 2'd1,
    V_FAIL    = 2'd2
  } verdict_t;

  typedef struct packed {
    logic clr;
    logic step;
    logic sym;
    logic pad;
  } sym_ctrl_t;

  typedef struct packed {
    logic pending;
    logic ok;
    logic pad_done;
  } sym_stat_t;

endpackage

// ----- rtl/core/irmfd_div.sv -----
// ----------------------------------------------------------------------------
// IR Manchester frame decoder: bit-serial divider
// Restoring division, one quotient bit per cycle; a zero divisor acts as one.
// ----------------------------------------------------------------------------
module irmfd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [irmfd_pkg::DIVD_W-1:0] dividend,
  input  logic [irmfd_pkg::UNIT_W-1:0] divisor,
  output logic                         busy,
  output logic [irmfd_pkg::DIVD_W-1:0] quotient
);
  import irmfd_pkg::*;

  logic [UNIT_W-1:0]    rem;
  logic [UNIT_W-1:0]    rem_next;
  logic [DIVD_W-1:0]    dq;
  logic [DIVD_W-1:0]    dq_next;
  logic [DIV_CNT_W-1:0] count;
  logic [UNIT_W-1:0]    dsr;
  logic [UNIT_W:0]      rem_sh;
  logic [UNIT_W:0]      trial;

  always_comb begin
    dsr    = (divisor == '0) ? UNIT_W'(1) : divisor;
    rem_sh = {rem, dq[DIVD_W-1]};
    trial  = rem_sh - {1'b0, dsr};
    if (rem_sh >= {1'b0, dsr}) begin
      rem_next = trial[UNIT_W-1:0];
      dq_next  = {dq[DIVD_W-2:0], 1'b1};
    end else begin
      rem_next = rem_sh[UNIT_W-1:0];
      dq_next  = {dq[DIVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= DIV_CNT_W'(DIVD_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // dividend bits shift out of the top as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= dq_next;
    end
  end

  assign quotient = dq;

endmodule

// ----- rtl/core/irmfd_sym.sv -----
// ----------------------------------------------------------------------------
// IR Manchester frame decoder: symbol engine
// Takes one symbol per cycle on step, tracks both headers and shifts decoded pairs in.
// ----------------------------------------------------------------------------
module irmfd_sym #(
  parameter int FRAME_BITS  = 34,
  parameter int MAX_SYMBOLS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  irmfd_pkg::sym_ctrl_t  ctrl,
  output irmfd_pkg::sym_stat_t  stat,
  output logic [FRAME_BITS-1:0] frame_bits
);
  import irmfd_pkg::*;

  localparam int POS_W = $clog2(MAX_SYMBOLS + 6);
  localparam int PC_W  = $clog2(FRAME_BITS + 1);

  logic [5:0]            hist;
  logic [5:0]            hist_next;
  logic [5:0]            hist_shift;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      pos_next;
  logic                  header_seen;
  logic                  header_seen_next;
  logic                  second_found;
  logic                  second_found_next;
  verdict_t              verdict;
  verdict_t              verdict_next;
  logic [FRAME_BITS-1:0] bits;
  logic [FRAME_BITS-1:0] bits_next;
  logic [PC_W-1:0]       pair_count;
  logic [PC_W-1:0]       pair_count_next;

  always_comb begin
    hist_next         = hist;
    pos_next          = pos;
    header_seen_next  = header_seen;
    second_found_next = second_found;
    verdict_next      = verdict;
    bits_next         = bits;
    pair_count_next   = pair_count;
    hist_shift        = {hist[4:0], ctrl.sym};
    if (ctrl.step && verdict == V_PENDING) begin
      if (second_found) begin
        // one symbol beyond the closing header
        verdict_next = V_OK;
      end else begin
        // pair starting six symbols back, read before the shift
        if (header_seen && pos >= POS_W'(12) && !pos[0] &&
            pair_count < PC_W'(FRAME_BITS)) begin
          bits_next       = FRAME_BITS'({bits, hist[5] & ~hist[4]});
          pair_count_next = pair_count + 1'b1;
        end
        hist_next = hist_shift;
        if (pos == POS_W'(5)) begin
          if (hist_shift == HDR_PATTERN) begin
            header_seen_next = 1'b1;
          end else begin
            verdict_next = V_FAIL;
          end
        end else if (pos >= POS_W'(11)) begin
          if (hist_shift == HDR_PATTERN && pos <= POS_W'(MAX_SYMBOLS + 4)) begin
            second_found_next = 1'b1;
          end else if (pos >= POS_W'(MAX_SYMBOLS + 4)) begin
            verdict_next = V_FAIL;
          end
        end
        pos_next = pos + 1'b1;
      end
    end else if (ctrl.pad && pair_count < PC_W'(FRAME_BITS)) begin
      // left-align a short frame
      bits_next       = FRAME_BITS'({bits, 1'b0});
      pair_count_next = pair_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      hist         <= '0;
      pos          <= '0;
      header_seen  <= 1'b0;
      second_found <= 1'b0;
      verdict      <= V_PENDING;
      bits         <= '0;
      pair_count   <= '0;
    end else begin
      hist         <= hist_next;
      pos          <= pos_next;
      header_seen  <= header_seen_next;
      second_found <= second_found_next;
      verdict      <= verdict_next;
      bits         <= bits_next;
      pair_count   <= pair_count_next;
    end
  end

  assign stat.pending  = (verdict == V_PENDING);
  assign stat.ok       = (verdict == V_OK);
  assign stat.pad_done = (pair_count == PC_W'(FRAME_BITS));
  assign frame_bits    = bits;

endmodule

// ----- rtl/core/ir_manchester_frame_decoder_core.sv -----
// ----------------------------------------------------------------------------
// IR Manchester frame decoder core
// Turns a captured mark/space sequence into a decoded air-conditioner frame.
// ----------------------------------------------------------------------------
// One entry is taken at a time. The leading gap entry and a trailing entry at
// an odd index add no symbols. Every other entry passes through the request,
// an operand load, the bit-serial divider converting ticks to half-bit units,
// the divider hand-over, a run of at most MAX_RUN symbols and the run exit;
// the symbol engine consumes one symbol per cycle and stops early once the
// frame is settled. The final entry then left-aligns the frame and loads the
// result register; the next entry is accepted while a result still waits to
// be taken, but its own result waits for that register.
`include "ir_manchester_frame_decoder_core_macros.svh"

module ir_manchester_frame_decoder_core #(
  parameter int FRAME_BITS  = 34,
  parameter int MAX_SYMBOLS = 256,
  parameter int MAX_RUN     = 255
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [irmfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irmfd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [irmfd_pkg::DUR_W-1:0]     duration_ticks,
  input  logic                            first_entry,
  input  logic                            last_entry,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            decoded_ok,
  output logic [FRAME_BITS-1:0]           decoded_value
);
  import irmfd_pkg::*;

  localparam int RUN_W = $clog2(MAX_RUN + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_DIV  = 6'b000100,
    S_RUN  = 6'b001000,
    S_PAD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t                  state;
  logic [UNIT_W-1:0]       unit_us;
  logic [MARGIN_W-1:0]     margin_us;
  logic [TICK_W-1:0]       tick_us;
  logic [DUR_W-1:0]        ticks;
  logic                    last;
  logic                    sym;
  logic [ENTRY_W-1:0]      entry_index;
  logic                    entry_odd;
  logic [RUN_W-1:0]        run;
  logic                    accept;
  logic [ENTRY_W-1:0]      eidx_eff;
  logic                    odd_eff;
  logic                    process;
  logic [DUR_W+TICK_W-1:0] prod;
  logic [DIVD_W-1:0]       dividend;
  logic                    div_start;
  logic                    div_busy;
  logic [DIVD_W-1:0]       div_q;
  logic [RUN_W-1:0]        run_sat;
  logic                    res_load;
  logic                    frame_ok;
  sym_ctrl_t               sctrl;
  sym_stat_t               sstat;
  logic [FRAME_BITS-1:0]   frame_bits;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_us   <= UNIT_US_RST;
      margin_us <= MARGIN_US_RST;
      tick_us   <= TICK_US_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UNIT_US:   unit_us   <= cfg_data[UNIT_W-1:0];
        CFG_MARGIN_US: margin_us <= cfg_data[MARGIN_W-1:0];
        CFG_TICK_US:   tick_us   <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  // a first entry restarts the capture before the gap test
  assign eidx_eff = first_entry ? '0 : entry_index;
  assign odd_eff  = first_entry ? 1'b0 : entry_odd;
  assign process  = (eidx_eff != '0) && !(odd_eff && last_entry);

  assign prod      = ticks * tick_us;
  assign dividend  = {1'b0, prod} + DIVD_W'(margin_us);
  assign div_start = (state == S_LOAD);
  assign run_sat   = (div_q > DIVD_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : div_q[RUN_W-1:0];

  assign res_load = (state == S_OUT) && (!result_valid || result_ready);
  assign frame_ok = sstat.ok && (entry_index >= MIN_ENTRIES);

  always_comb begin
    sctrl.clr  = (accept && first_entry) || res_load;
    sctrl.step = (state == S_RUN) && (run != '0) && sstat.pending;
    sctrl.sym  = sym;
    sctrl.pad  = (state == S_PAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_index <= '0;
      entry_odd   <= 1'b0;
      run         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            entry_index <= (eidx_eff < MIN_ENTRIES) ? eidx_eff + 1'b1 : eidx_eff;
            entry_odd   <= !odd_eff;
            if (process) begin
              state <= S_LOAD;
            end else if (last_entry) begin
              state <= S_PAD;
            end
          end
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy) begin
            run   <= run_sat;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (run != '0 && sstat.pending) begin
            run <= run - 1'b1;
          end else begin
            run   <= '0;
            state <= last ? S_PAD : S_IDLE;
          end
        end
        S_PAD: begin
          if (sstat.pad_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_load) begin
            entry_index <= '0;
            entry_odd   <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request fields held for the whole conversion
  always_ff @(posedge clk) begin
    if (accept) begin
      ticks <= duration_ticks;
      last  <= last_entry;
      sym   <= !odd_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      decoded_ok    <= frame_ok;
      decoded_value <= frame_ok ? frame_bits : '0;
    end
  end

  irmfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (unit_us),
    .busy     (div_busy),
    .quotient (div_q)
  );

  irmfd_sym #(
    .FRAME_BITS  (FRAME_BITS),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_sym (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (sctrl),
    .stat       (sstat),
    .frame_bits (frame_bits)
  );

  `IRMFD_ASSERT_IMPLY(a_div_busy_in_div, clk, rst, div_busy, state == S_DIV, "divider busy outside divide state")
  `IRMFD_ASSERT_NEVER(a_entry_sat, clk, rst, entry_index > MIN_ENTRIES, "entry count beyond saturation")
  `IRMFD_ASSERT_IMPLY(a_fail_zero, clk, rst, result_valid && !decoded_ok, decoded_value == '0, "failed frame carries data")

endmodule

// ----- sim/tb_ir_manchester_frame_decoder_core.sv -----
// ----------------------------------------------------------------------------
// IR Manchester frame decoder core: testbench
// Feeds captured mark/space sequences through the item channel, predicts the
// verdict of every closed capture in a local decoder model and compares each
// result field by field. Directed captures first, then random frames, some
// malformed, and noise under several register settings, with random idling
// on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_ir_manchester_frame_decoder_core;
  import irmfd_pkg::*;

  localparam int FRAME_W        = 34;
  localparam int SYM_LIMIT      = 256;
  localparam int RUN_CAP        = 255;
  localparam int SETTLE_CYCLES  = 400;
  localparam int HOLD_CYCLES    = 5000;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] value;
  } frame_verdict_t;

  logic                 clk            = 1'b0;
  logic                 rst            = 1'b1;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CFG_W-1:0]     cfg_data       = '0;
  logic                 item_valid     = 1'b0;
  logic                 item_ready;
  logic [DUR_W-1:0]     duration_ticks = '0;
  logic                 first_entry    = 1'b0;
  logic                 last_entry     = 1'b0;
  logic                 result_valid;
  logic                 result_ready   = 1'b0;
  logic                 decoded_ok;
  logic [FRAME_W-1:0]   decoded_value;

  ir_manchester_frame_decoder_core DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .duration_ticks (duration_ticks),
    .first_entry    (first_entry),
    .last_entry     (last_entry),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .decoded_ok     (decoded_ok),
    .decoded_value  (decoded_value)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // register copies and capture state of the local decoder
  logic [UNIT_W-1:0]   unit_cfg   = UNIT_US_RST;
  logic [MARGIN_W-1:0] margin_cfg = MARGIN_US_RST;
  logic [TICK_W-1:0]   tick_cfg   = TICK_US_RST;

  bit [3:0]           entries_seen;
  bit                 odd_entry;
  bit [5:0]           sym_hist;
  int unsigned        sym_pos;
  bit                 hdr_found;
  int unsigned        hdr2_pos;
  bit [FRAME_W-1:0]   frame_acc;
  int unsigned        pairs_done;
  verdict_t           frame_state = V_PENDING;

  frame_verdict_t expected_verdicts[$];
  frame_verdict_t want;
  int             mismatches  = 0;
  int             items_sent  = 0;
  int             quiet_cycles = 0;
  bit             prev_was_last = 1'b0;
  bit             tx_bursty = 1'b1;
  bit             calm = 1'b0;
  logic           hold_req = 1'b0;
  bit             hold_taken = 1'b0;
  int             hold_left, stall_left, quiet_left;

  bit symbols[$];

  function void clear_capture();
    entries_seen = '0;
    odd_entry    = 1'b0;
    sym_hist     = '0;
    sym_pos      = 0;
    hdr_found    = 1'b0;
    hdr2_pos     = 0;
    frame_acc    = '0;
    pairs_done   = 0;
    frame_state  = V_PENDING;
  endfunction

  function void push_symbol(bit s);
    int unsigned p;
    if (frame_state != V_PENDING) return;
    if (hdr2_pos != 0) begin
      frame_state = V_OK;
      return;
    end
    // pair starting six symbols back is committed before the shift
    if (hdr_found && sym_pos >= 12 && (sym_pos % 2) == 0) begin
      if (pairs_done < FRAME_W) begin
        if (sym_hist[5:4] == 2'b10) frame_acc[FRAME_W-1-pairs_done] = 1'b1;
        pairs_done++;
      end
    end
    sym_hist = {sym_hist[4:0], s};
    if (sym_pos == 5) begin
      if (sym_hist == HDR_PATTERN) hdr_found = 1'b1;
      else frame_state = V_FAIL;
    end else if (sym_pos >= 11) begin
      p = sym_pos - 5;
      if (sym_hist == HDR_PATTERN && p <= SYM_LIMIT - 1) hdr2_pos = p;
      else if (p >= SYM_LIMIT - 1) frame_state = V_FAIL;
    end
    sym_pos++;
  endfunction

  function void decode_entry(logic [DUR_W-1:0] ticks, bit is_first, bit is_last);
    int unsigned    divisor, units, run;
    frame_verdict_t fv;
    if (is_first) clear_capture();
    // gap entry and a closing entry at an odd index add no symbols
    if (entries_seen != 0 && !(odd_entry && is_last)) begin
      divisor = (unit_cfg == 0) ? 1 : 32'(unit_cfg);
      units   = (32'(ticks) * 32'(tick_cfg) + 32'(margin_cfg)) / divisor;
      run     = (units > RUN_CAP) ? RUN_CAP : units;
      while (run > 0 && frame_state == V_PENDING) begin
        push_symbol(!odd_entry);
        run--;
      end
    end
    if (entries_seen < MIN_ENTRIES) entries_seen++;
    odd_entry = !odd_entry;
    if (is_last) begin
      fv.ok    = (entries_seen >= MIN_ENTRIES) && (frame_state == V_OK);
      fv.value = fv.ok ? frame_acc : '0;
      expected_verdicts.insert(expected_verdicts.size(), fv);
      clear_capture();
    end
  endfunction

  // duration in ticks that converts to u whole units under the current setting
  function logic [DUR_W-1:0] ticks_for(int unsigned u);
    longint d, lo, hi;
    if (tick_cfg == 0) return DUR_W'($urandom_range(0, 65535));
    d  = (unit_cfg == 0) ? 1 : longint'(unit_cfg);
    lo = longint'(u) * d - longint'(margin_cfg);
    lo = (lo <= 0) ? 0 : (lo + tick_cfg - 1) / tick_cfg;
    hi = (longint'(u) + 1) * d - 1 - longint'(margin_cfg);
    hi = (hi < 0) ? lo : hi / tick_cfg;
    if (hi < lo) hi = lo;
    if (lo > 65535) lo = 65535;
    if (hi > 65535) hi = 65535;
    return DUR_W'($urandom_range(32'(hi), 32'(lo)));
  endfunction

  // sends one request and holds it until taken
  task automatic send_entry(logic [DUR_W-1:0] ticks, bit is_first, bit is_last);
    int gap;
    item_valid     <= 1'b1;
    duration_ticks <= ticks;
    first_entry    <= is_first;
    last_entry     <= is_last;
    do @(posedge clk); while (!item_ready);
    decode_entry(ticks, is_first, is_last);
    prev_was_last = is_last;
    items_sent++;
    gap = 0;
    if (!calm && tx_bursty && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_UNIT_US:   unit_cfg   = data;
      CFG_MARGIN_US: margin_cfg = data;
      CFG_TICK_US:   tick_cfg   = data[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [CFG_W-1:0] unit, logic [CFG_W-1:0] margin,
                            logic [CFG_W-1:0] tick);
    write_reg(CFG_UNIT_US, unit);
    write_reg(CFG_MARGIN_US, margin);
    write_reg(CFG_TICK_US, tick);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // frame symbols: header, Manchester data, closing header; faults unless clean
  task automatic build_frame(bit clean, output int tail);
    int kind, nbits, r;
    bit b;
    symbols.delete();
    kind = clean ? 99 : $urandom_range(0, 99);
    symbols = {1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
    if (kind < 5) begin
      r = $urandom_range(0, 5);
      symbols[r] = !symbols[r];
    end
    if (kind >= 5 && kind < 8) nbits = $urandom_range(122, 128);
    else if (kind < 45) nbits = $urandom_range(1, 48);
    else nbits = FRAME_W;
    for (int i = 0; i < nbits; i++) begin
      if (!clean && $urandom_range(0, 19) == 0) begin
        symbols.insert(symbols.size(), 1'($urandom_range(0, 1)));
        symbols.insert(symbols.size(), 1'($urandom_range(0, 1)));
      end else begin
        b = $urandom_range(0, 1);
        symbols.insert(symbols.size(), b);
        symbols.insert(symbols.size(), !b);
      end
    end
    if (!clean && $urandom_range(0, 9) == 0)
      symbols.insert($urandom_range(6, symbols.size()), 1'($urandom_range(0, 1)));
    if (clean || $urandom_range(0, 19) != 0) begin
      for (int i = 5; i >= 0; i--) symbols.insert(symbols.size(), HDR_PATTERN[i]);
      if (clean || $urandom_range(0, 9) != 0) symbols.insert(symbols.size(), 1'b1);
    end else begin
      repeat ($urandom_range(1, 8)) symbols.insert(symbols.size(), 1'($urandom_range(0, 1)));
    end
    tail = $urandom_range(0, 3);
  endtask

  // gap entry, one entry per symbol run, then tail entries; last one closes
  task automatic send_capture(int tail, bit free_gap);
    int unsigned runs[$];
    bit          is_first;
    int unsigned u;
    if (symbols.size() == 0 || symbols[0]) runs.insert(runs.size(), 32'd0);
    foreach (symbols[i]) begin
      if (i > 0 && symbols[i] == symbols[i-1]) runs[runs.size()-1]++;
      else runs.insert(runs.size(), 32'd1);
    end
    // after a closed capture the gap may come without its flag
    is_first = !(free_gap && prev_was_last && $urandom_range(0, 3) == 0);
    send_entry(DUR_W'($urandom_range(0, 65535)), is_first, runs.size() == 0 && tail == 0);
    foreach (runs[i]) send_entry(ticks_for(runs[i]), 1'b0, i == runs.size() - 1 && tail == 0);
    for (int k = 0; k < tail; k++) begin
      u = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 400) : $urandom_range(0, 3);
      send_entry(ticks_for(u), 1'b0, k == tail - 1);
    end
  endtask

  task automatic send_noise(int n);
    repeat (n)
      send_entry(DUR_W'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0,
                 $urandom_range(0, 5) == 0);
  endtask

  task automatic test_short_captures();
    send_entry(16'hFFFF, 1'b1, 1'b1);   // gap and last in one entry
    send_entry(16'h0000, 1'b1, 1'b0);
    send_entry(ticks_for(3), 1'b0, 1'b0);
    send_entry(ticks_for(3), 1'b0, 1'b0); // left open; next capture restarts
  endtask

  task automatic test_minimal_frame();
    bit [16:0] pat;
    pat = 17'b00011110100001111;
    symbols.delete();
    for (int i = 16; i >= 0; i--) symbols.insert(symbols.size(), pat[i]);
    // twelve entries, closing on an odd index that is skipped
    send_capture(5, 1'b0);
  endtask

  task automatic test_bad_header();
    send_entry(16'h1234, 1'b0, 1'b0);   // gap by position, flag low
    send_entry(16'hFFFF, 1'b0, 1'b0);   // saturated zero run
    send_entry(ticks_for(3), 1'b0, 1'b0);
    send_entry(16'h0000, 1'b0, 1'b0);
    send_entry(ticks_for(2), 1'b0, 1'b1);
  endtask

  task automatic test_result_backpressure();
    int tail;
    hold_req <= 1'b1;
    repeat (3) begin
      build_frame(1'b1, tail);
      send_capture(1, 1'b0);
    end
    wait_idle();
  endtask

  task automatic test_random_phases();
    int start, budget, tail, u;
    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      case (ph)
        0: set_config(16'd992, 16'd150, 16'd50);
        1: set_config(16'd560, 16'd100, 16'd10);
        2: set_config(16'd0, 16'd0, 16'd1);          // unit of zero acts as one
        3: set_config(16'hFFFF, 16'hFFFF, 16'd255);
        4: set_config(16'd1, 16'hFFFF, 16'd0);       // every run saturates
        5: begin
          u = $urandom_range(300, 5000);
          set_config(16'(u), 16'($urandom_range(0, u / 2)),
                     {8'($urandom_range(0, 255)), 8'($urandom_range(1, 60))});
        end
        default: begin
          set_config(UNIT_US_RST, MARGIN_US_RST, 16'(TICK_US_RST));
          calm <= 1'b1;
        end
      endcase
      budget = (ph == 4) ? 60 : 150;
      start  = items_sent;
      while (items_sent - start < budget) begin
        tx_bursty = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 8));
        build_frame(1'b0, tail);
        send_capture(tail, 1'b1);
      end
    end
    wait_idle();
  endtask

  // result side: random stalls, quiet stretches and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      hold_left    <= 0;
      stall_left   <= 0;
      quiet_left   <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken   <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_ready <= 1'b0;
    end else if (calm || quiet_left != 0) begin
      if (quiet_left != 0) quiet_left <= quiet_left - 1;
      result_ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1: begin
          stall_left   <= $urandom_range(0, 12);
          result_ready <= 1'b0;
        end
        2: begin
          quiet_left   <= $urandom_range(50, 300);
          result_ready <= 1'b1;
        end
        default: result_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result with nothing expected: ok=%0b value=%h",
                 $time, decoded_ok, decoded_value);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (decoded_ok !== want.ok) begin
          $display("%0t: decoded_ok expected %0b actual %0b", $time, want.ok, decoded_ok);
          mismatches++;
        end
        if (decoded_value !== want.value) begin
          $display("%0t: decoded_value expected %h actual %h",
                   $time, want.value, decoded_value);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** ir_manchester_frame_decoder_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_capture();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_short_captures();
    test_minimal_frame();
    test_bad_header();
    test_result_backpressure();
    test_random_phases();
    if (mismatches == 0) begin
      $display("** ir_manchester_frame_decoder_core: PASSED **");
    end else begin
      $display("** ir_manchester_frame_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
